// ===== rtl/lfctp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lfctp_pkg;

	// command codes on the input channel
	localparam logic [1:0] CMD_TICK        = 2'd0;
	localparam logic [1:0] CMD_LOAD_NORMAL = 2'd1;
	localparam logic [1:0] CMD_LOAD_FAST   = 2'd2;

	// configuration register indexes
	localparam logic REG_PARSE_ERROR = 1'b0;
	localparam logic REG_LEVEL_COUNT = 1'b1;

	localparam logic [3:0] LEVEL_COUNT_RESET = 4'd15;

	// temperature limits in 0.1 C
	localparam logic signed [11:0] TEMP_HOT_LATCH = 12'sd410;
	localparam logic signed [11:0] TEMP_FAST_OFF  = 12'sd420;

	// current steps in mA
	localparam logic [15:0] CUR_SUB_A_MIN = 16'd5450;
	localparam logic [15:0] CUR_SUB_A     = 16'd3300;
	localparam logic [15:0] CUR_SUB_B_MIN = 16'd3950;
	localparam logic [15:0] CUR_SUB_B     = 16'd1800;
	localparam logic [15:0] CUR_SUB_C_MIN = 16'd3150;
	localparam logic [15:0] CUR_STEP_2000 = 16'd2000;
	localparam logic [15:0] CUR_SUB_D     = 16'd1000;
	localparam logic [15:0] CUR_FLOOR     = 16'd2150;
	localparam logic [15:0] CUR_ADD_MAX   = 16'd10200;
	localparam logic [15:0] CUR_CEILING   = 16'd12200;

	// fast-table adjustment selected from soc and board temperature
	typedef enum logic [2:0] {
		ADJ_NONE,
		ADJ_SUB_A,
		ADJ_SUB_B,
		ADJ_SUB_C,
		ADJ_SUB_D,
		ADJ_ADD
	} adj_mode_t;

	typedef struct packed {
		logic      vote;
		logic      use_fast;
		adj_mode_t adj;
		logic      fast_held;
	} tick_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/lfctp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfctp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/low_fast_charge_thermal_policy_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Fast-charge current policy. A transaction is either a table load (normal or fast
// table, one entry of LEVEL_SLOTS) or a monitor tick; every transaction yields one
// result transaction. One transaction is accepted per cycle while in_stall is low, and
// its result passes the table read register and then the output register: the
// accepting edge launches the synchronous read of the current tables, and the edge
// at which the output advances adds the soc and temperature step and loads the output
// register. Screen phase, hot latch and fast-mode state live in flip-flops and are
// updated at the accepting edge of a tick that applies the policy. Tables come out of
// reset unwritten and need no clearing pass; a tick must only select entries that were
// loaded. Configuration may be written only while idle.
module low_fast_charge_thermal_policy_unit #(
	parameter int LEVEL_SLOTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write_en,
	input  wire logic               cfg_index,
	input  wire logic [3:0]         cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic [3:0]         table_index,
	input  wire logic [15:0]        table_value,
	input  wire logic [6:0]         soc,
	input  wire logic signed [4:0]  temp_level,
	input  wire logic signed [11:0] board_temp,
	input  wire logic               pps_active,
	input  wire logic               plugin_flag,
	input  wire logic               low_fast_enabled,
	input  wire logic               screen_black,
	input  wire logic [31:0]        now_seconds,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    vote_valid,
	output logic [15:0]             current_limit,
	output logic                    fast_mode
);

	import lfctp_pkg::*;

	localparam int SW = $clog2(LEVEL_SLOTS);

	localparam logic [1:0] PHASE_NORMAL = 2'd0;
	localparam logic [1:0] PHASE_BLACK  = 2'd1;
	localparam logic [1:0] PHASE_WAKE   = 2'd2;
	localparam logic [1:0] PHASE_BRIGHT = 2'd3;

	logic              parse_error_q;
	logic [3:0]        level_count_q;
	logic [1:0]        screen_phase_q;
	logic [31:0]       bright_since_q;
	logic signed [4:0] previous_level_q;
	logic              hot_latch_q;
	logic              fast_held_q;

	logic              vld_s1;
	tick_ctl_t         ctl_s1;

	logic              accept;
	logic              advance;
	logic              tick;
	logic              lvl_pos;
	logic              eligible;
	logic              policy;
	logic [SW-1:0]     slot;
	logic              load_normal;
	logic              load_fast;
	logic [SW-1:0]     waddr;
	logic [1:0]        phase_next;
	logic              fast_screen;
	logic              fast_final;
	logic              hot_set;
	logic              hot_hold;
	adj_mode_t         adj;
	tick_ctl_t         ctl_next;
	logic [15:0]       normal_rd;
	logic [15:0]       fast_rd;
	logic [15:0]       fast_adj;

	assign advance  = !out_valid || !out_stall;
	assign in_stall = vld_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// table write and read addresses
	always_comb begin
		waddr = SW'(table_index);
		if (temp_level[4]) begin
			slot = '0;
		end else if ({2'b00, temp_level[3:0]} > 6'(LEVEL_SLOTS - 1)) begin
			slot = SW'(LEVEL_SLOTS - 1);
		end else begin
			slot = SW'(temp_level[3:0]);
		end
	end

	assign load_normal = accept && cmd == CMD_LOAD_NORMAL
		&& {2'b00, table_index} < 6'(LEVEL_SLOTS);
	assign load_fast   = accept && cmd == CMD_LOAD_FAST
		&& {2'b00, table_index} < 6'(LEVEL_SLOTS);

	lfctp_ram #(.WIDTH(16), .DEPTH(LEVEL_SLOTS)) u_normal_ram (
		.clk  (clk),
		.we   (load_normal),
		.waddr(waddr),
		.wdata(table_value),
		.re   (accept),
		.raddr(slot),
		.rdata(normal_rd)
	);

	lfctp_ram #(.WIDTH(16), .DEPTH(LEVEL_SLOTS)) u_fast_ram (
		.clk  (clk),
		.we   (load_fast),
		.waddr(waddr),
		.wdata(table_value),
		.re   (accept),
		.raddr(slot),
		.rdata(fast_rd)
	);

	// tick decision on the scalar state
	always_comb begin
		tick     = accept && cmd == CMD_TICK;
		lvl_pos  = !temp_level[4] && temp_level != 5'sd0;
		eligible = pps_active && soc <= 7'd40 && plugin_flag && low_fast_enabled;
		policy   = tick && lvl_pos && eligible && !parse_error_q
			&& !(temp_level[3:0] > level_count_q);

		if (screen_phase_q <= PHASE_BLACK && !screen_black) begin
			phase_next  = PHASE_WAKE;
			fast_screen = 1'b1;
		end else if (!screen_black) begin
			phase_next  = PHASE_BRIGHT;
			fast_screen = (now_seconds - bright_since_q) <= 32'd10;
		end else begin
			phase_next  = PHASE_BLACK;
			fast_screen = 1'b1;
		end

		hot_set  = previous_level_q == 5'sd8 && temp_level == 5'sd7
			&& board_temp > TEMP_HOT_LATCH;
		hot_hold = !hot_set && previous_level_q == 5'sd7
			&& (temp_level == 5'sd7 || temp_level == 5'sd8)
			&& hot_latch_q && board_temp > TEMP_HOT_LATCH;
		fast_final = fast_screen && !hot_set && !hot_hold
			&& !(board_temp > TEMP_FAST_OFF);

		if (soc > 7'd38 && board_temp > 12'sd380) begin
			adj = ADJ_SUB_A;
		end else if (soc > 7'd35 && board_temp > 12'sd390) begin
			adj = ADJ_SUB_B;
		end else if (soc > 7'd30 && board_temp > 12'sd409) begin
			adj = ADJ_SUB_C;
		end else if (soc < 7'd30 && board_temp > 12'sd409) begin
			adj = ADJ_SUB_D;
		end else if (soc > 7'd30 && soc < 7'd39 && board_temp < 12'sd389) begin
			adj = ADJ_ADD;
		end else if (soc <= 7'd30 && board_temp < 12'sd366) begin
			adj = ADJ_ADD;
		end else begin
			adj = ADJ_NONE;
		end

		ctl_next.vote      = tick && (!lvl_pos || eligible);
		ctl_next.use_fast  = policy && fast_final;
		ctl_next.adj       = adj;
		ctl_next.fast_held = policy ? fast_final : fast_held_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_error_q    <= 1'b0;
			level_count_q    <= LEVEL_COUNT_RESET;
			screen_phase_q   <= PHASE_NORMAL;
			bright_since_q   <= '0;
			previous_level_q <= '0;
			hot_latch_q      <= 1'b0;
			fast_held_q      <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_index)
					REG_PARSE_ERROR: parse_error_q <= cfg_data[0];
					REG_LEVEL_COUNT: level_count_q <= cfg_data;
					default: ;
				endcase
			end
			if (policy) begin
				screen_phase_q   <= phase_next;
				if (screen_phase_q <= PHASE_BLACK && !screen_black) begin
					bright_since_q <= now_seconds;
				end
				hot_latch_q      <= hot_set || hot_hold;
				fast_held_q      <= fast_final;
				previous_level_q <= temp_level;
			end
		end
	end

	// table read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_next;
		end
	end

	// soc and temperature step on the fast entry
	always_comb begin
		case (ctl_s1.adj)
			ADJ_SUB_A: fast_adj = (fast_rd >= CUR_SUB_A_MIN) ? fast_rd - CUR_SUB_A : CUR_FLOOR;
			ADJ_SUB_B: fast_adj = (fast_rd >= CUR_SUB_B_MIN) ? fast_rd - CUR_SUB_B : CUR_FLOOR;
			ADJ_SUB_C: fast_adj = (fast_rd >= CUR_SUB_C_MIN) ? fast_rd - CUR_STEP_2000
				: CUR_FLOOR;
			ADJ_SUB_D: fast_adj = (fast_rd >= CUR_SUB_C_MIN) ? fast_rd - CUR_SUB_D : CUR_FLOOR;
			ADJ_ADD:   fast_adj = (fast_rd <= CUR_ADD_MAX) ? fast_rd + CUR_STEP_2000
				: CUR_CEILING;
			default:   fast_adj = fast_rd;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			vote_valid <= ctl_s1.vote;
			fast_mode  <= ctl_s1.fast_held;
			if (!ctl_s1.vote) begin
				current_limit <= '0;
			end else if (ctl_s1.use_fast) begin
				current_limit <= fast_adj;
			end else begin
				current_limit <= normal_rd;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lfctp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfctp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        vote_valid,
	input wire logic [15:0] current_limit,
	input wire logic        fast_mode
);

	// an empty output register never holds off the input
	a_no_stall_when_empty: assert property (
		@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall
	) else $error("input stalled while output register empty");

	// a transaction without a vote carries a zero limit
	a_no_vote_zero_limit: assert property (
		@(posedge clk) disable iff (!arst_n)
		out_valid && !vote_valid |-> current_limit == 16'd0
	) else $error("nonzero limit without vote");

	a_out_hold: assert property (
		@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vote_valid)
			&& $stable(current_limit) && $stable(fast_mode)
	) else $error("stalled result changed");

endmodule

bind low_fast_charge_thermal_policy_unit lfctp_checker u_lfctp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.vote_valid   (vote_valid),
	.current_limit(current_limit),
	.fast_mode    (fast_mode)
);

`default_nettype wire

// ===== tb/tb_low_fast_charge_thermal_policy_unit.sv =====
`timescale 1ns / 1ps

module tb_low_fast_charge_thermal_policy_unit;
	import lfctp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [1:0] {
		SCR_NORMAL,
		SCR_BLACK,
		SCR_TO_BRIGHT,
		SCR_BRIGHT
	} screen_phase_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [3:0]         idx;
		logic [15:0]        val;
		logic [6:0]         soc;
		logic signed [4:0]  lvl;
		logic signed [11:0] temp;
		logic               pps;
		logic               plug;
		logic               en;
		logic               black;
		logic [31:0]        now;
	} policy_item_t;

	typedef struct packed {
		logic        vote;
		logic [15:0] limit;
		logic        fast;
	} vote_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_write_en;
	logic               cfg_index;
	logic [3:0]         cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         cmd;
	logic [3:0]         table_index;
	logic [15:0]        table_value;
	logic [6:0]         soc;
	logic signed [4:0]  temp_level;
	logic signed [11:0] board_temp;
	logic               pps_active;
	logic               plugin_flag;
	logic               low_fast_enabled;
	logic               screen_black;
	logic [31:0]        now_seconds;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               vote_valid;
	logic [15:0]        current_limit;
	logic               fast_mode;

	// predictor state
	screen_phase_t ph_screen;
	logic [31:0]   bright_t0;
	int            prev_lvl;
	logic          latch_hot;
	logic          held_fast;
	logic [15:0]   norm_cur [16];
	logic [15:0]   fast_cur [16];
	logic          cfg_parse_err;
	logic [3:0]    cfg_top_level;

	vote_t       pending_votes [$];
	vote_t       got_vote;
	vote_t       want_vote;
	logic        calm;
	logic [31:0] clock_s;
	int          cycles;
	int          mismatches;
	int          n_loads;
	int          n_ticks;
	int          n_votes;
	int          n_fast_votes;
	int          n_results;
	int          n_settings;

	low_fast_charge_thermal_policy_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_en     (cfg_write_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cmd              (cmd),
		.table_index      (table_index),
		.table_value      (table_value),
		.soc              (soc),
		.temp_level       (temp_level),
		.board_temp       (board_temp),
		.pps_active       (pps_active),
		.plugin_flag      (plugin_flag),
		.low_fast_enabled (low_fast_enabled),
		.screen_black     (screen_black),
		.now_seconds      (now_seconds),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.vote_valid       (vote_valid),
		.current_limit    (current_limit),
		.fast_mode        (fast_mode)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_votes.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 23);
	end

	// soc and temperature step on a fast table entry
	function automatic logic [15:0] fast_step(input logic [15:0] c, input int soc_i,
			input int t_i);
		int c_i;
		c_i = c;
		if (soc_i > 38 && t_i > 380)
			c_i = (c_i >= 5450) ? c_i - 3300 : 2150;
		else if (soc_i > 35 && t_i > 390)
			c_i = (c_i >= 3950) ? c_i - 1800 : 2150;
		else if (soc_i > 30 && t_i > 409)
			c_i = (c_i >= 3150) ? c_i - 2000 : 2150;
		else if (soc_i < 30 && t_i > 409)
			c_i = (c_i >= 3150) ? c_i - 1000 : 2150;
		else if (soc_i > 30 && soc_i < 39 && t_i < 389)
			c_i = (c_i <= 10200) ? c_i + 2000 : 12200;
		else if (soc_i <= 30 && t_i < 366)
			c_i = (c_i <= 10200) ? c_i + 2000 : 12200;
		return c_i[15:0];
	endfunction

	function automatic vote_t policy_predict(input policy_item_t it);
		vote_t       r;
		int          lvl_i;
		int          t_i;
		int          soc_i;
		int          slot;
		logic        fast;
		logic [31:0] dt;
		r = '0;
		lvl_i = it.lvl;
		t_i = it.temp;
		soc_i = it.soc;
		slot = (lvl_i < 0) ? 0 : lvl_i;
		if (it.cmd == CMD_LOAD_NORMAL) begin
			norm_cur[it.idx] = it.val;
		end else if (it.cmd == CMD_LOAD_FAST) begin
			fast_cur[it.idx] = it.val;
		end else if (it.cmd == CMD_TICK) begin
			if (lvl_i <= 0) begin
				r.vote = 1'b1;
				r.limit = norm_cur[slot];
			end else if (it.pps && soc_i <= 40 && it.plug && it.en) begin
				if (cfg_parse_err || lvl_i > int'(cfg_top_level)) begin
					r.vote = 1'b1;
					r.limit = norm_cur[slot];
				end else begin
					if ((ph_screen == SCR_NORMAL || ph_screen == SCR_BLACK) && !it.black) begin
						ph_screen = SCR_TO_BRIGHT;
						bright_t0 = it.now;
						fast = 1'b1;
					end else if (!it.black) begin
						ph_screen = SCR_BRIGHT;
						dt = it.now - bright_t0;
						fast = (dt <= 32'd10);
					end else begin
						ph_screen = SCR_BLACK;
						fast = 1'b1;
					end
					if (prev_lvl == 8 && lvl_i == 7 && t_i > 410) begin
						latch_hot = 1'b1;
						fast = 1'b0;
					end else if (prev_lvl == 7 && (lvl_i == 7 || lvl_i == 8) && latch_hot
							&& t_i > 410) begin
						fast = 1'b0;
					end else begin
						latch_hot = 1'b0;
					end
					if (t_i > 420)
						fast = 1'b0;
					held_fast = fast;
					r.limit = fast ? fast_step(fast_cur[slot], soc_i, t_i) : norm_cur[slot];
					r.vote = 1'b1;
					prev_lvl = lvl_i;
				end
			end
		end
		r.fast = held_fast;
		return r;
	endfunction

	task automatic send_item(input policy_item_t it);
		while (!calm && $urandom_range(0, 99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.cmd;
		table_index <= it.idx;
		table_value <= it.val;
		soc <= it.soc;
		temp_level <= it.lvl;
		board_temp <= it.temp;
		pps_active <= it.pps;
		plugin_flag <= it.plug;
		low_fast_enabled <= it.en;
		screen_black <= it.black;
		now_seconds <= it.now;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_votes.push_back(policy_predict(it));
		if (it.cmd == CMD_TICK)
			n_ticks++;
		else
			n_loads++;
	endtask

	task automatic send_tick(input logic [6:0] s, input logic signed [4:0] lvl,
			input logic signed [11:0] t, input logic pps, input logic plug, input logic en,
			input logic black, input logic [31:0] now);
		policy_item_t it;
		it.cmd = CMD_TICK;
		it.idx = 4'($urandom);
		it.val = 16'($urandom);
		it.soc = s;
		it.lvl = lvl;
		it.temp = t;
		it.pps = pps;
		it.plug = plug;
		it.en = en;
		it.black = black;
		it.now = now;
		send_item(it);
	endtask

	task automatic send_load(input logic [1:0] op, input logic [3:0] idx,
			input logic [15:0] val);
		policy_item_t it;
		it = policy_item_t'({$urandom, $urandom, $urandom});
		it.cmd = op;
		it.idx = idx;
		it.val = val;
		send_item(it);
	endtask

	task automatic write_reg(input logic idx, input logic [3:0] data);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		if (idx == REG_PARSE_ERROR)
			cfg_parse_err = data[0];
		else
			cfg_top_level = data;
		n_settings++;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_votes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_random_item();
		int                 r;
		logic signed [4:0]  lvl;
		logic signed [11:0] t;
		logic [2:0]         flags;
		r = $urandom_range(0, 99);
		clock_s += $urandom_range(0, 3);
		if ($urandom_range(0, 49) == 0)
			clock_s += $urandom_range(8, 30);
		if ($urandom_range(0, 99) == 0)
			clock_s = $urandom;
		if (r < 6) begin
			send_load(($urandom_range(0, 1) != 0) ? CMD_LOAD_FAST : CMD_LOAD_NORMAL,
				4'($urandom_range(0, 15)), 16'($urandom));
		end else if (r < 12) begin
			send_tick(7'($urandom_range(0, 100)), 5'($urandom_range(0, 31)),
				12'(int'($urandom_range(0, 3071)) - 1024), 1'($urandom), 1'($urandom),
				1'($urandom), 1'($urandom), $urandom);
		end else if (r < 18) begin
			send_tick(7'($urandom_range(0, 100)), 5'($urandom_range(16, 32)),
				12'(int'($urandom_range(0, 3071)) - 1024), 1'($urandom), 1'($urandom),
				1'($urandom), 1'($urandom), clock_s);
		end else begin
			// well-formed tick, mostly eligible, often around the hot latch levels
			if ($urandom_range(0, 9) < 4)
				lvl = 5'($urandom_range(7, 8));
			else
				lvl = 5'($urandom_range(1, 15));
			if ($urandom_range(0, 9) < 7)
				t = 12'($urandom_range(355, 430));
			else
				t = 12'($urandom_range(200, 600));
			flags = 3'b111;
			if ($urandom_range(0, 19) == 0)
				flags[$urandom_range(0, 2)] = 1'b0;
			send_tick(7'($urandom_range(0, 40)), lvl, t, flags[0], flags[1], flags[2],
				$urandom_range(0, 9) < 3, clock_s);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_vote = '{vote_valid, current_limit, fast_mode};
			n_results++;
			if (vote_valid) begin
				n_votes++;
				if (fast_mode)
					n_fast_votes++;
			end
			if (pending_votes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: vote=%0b limit=%0d fast=%0b", vote_valid,
						current_limit, fast_mode);
			end else begin
				want_vote = pending_votes.pop_front();
				if (got_vote !== want_vote) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected vote=%0b limit=%0d fast=%0b,",
							n_results, want_vote.vote, want_vote.limit, want_vote.fast,
							" got vote=%0b limit=%0d fast=%0b",
							got_vote.vote, got_vote.limit, got_vote.fast);
				end
			end
		end
	end

	task automatic test_reset_config();
		write_reg(REG_PARSE_ERROR, 4'd0);
		write_reg(REG_LEVEL_COUNT, 4'd15);
	endtask

	// every entry of both tables gets written before any tick reads one
	task automatic test_table_load();
		logic [15:0] fast_vals [16];
		fast_vals = '{16'd4000, 16'd3950, 16'd3949, 16'd3150, 16'd3149, 16'd10200,
			16'd10201, 16'd5450, 16'd5449, 16'hFFFF, 16'd0, 16'd6000, 16'd7000, 16'd8000,
			16'd9000, 16'd11000};
		for (int i = 0; i < 16; i++)
			send_load(CMD_LOAD_NORMAL, 4'(i), (i == 0) ? 16'hFFFF :
				(i == 15) ? 16'd0 : 16'($urandom_range(500, 4000)));
		for (int i = 0; i < 16; i++)
			send_load(CMD_LOAD_FAST, 4'(i), fast_vals[i]);
	endtask

	task automatic test_directed_ticks();
		// error path
		send_tick(7'd100, -5'sd16, 12'sd300, 1'b1, 1'b1, 1'b1, 1'b0, 32'd90);
		send_tick(7'd20, 5'sd0, 12'sd300, 1'b0, 1'b0, 1'b0, 1'b1, 32'd95);
		// not eligible
		send_tick(7'd20, 5'sd5, 12'sd300, 1'b0, 1'b1, 1'b1, 1'b0, 32'd96);
		send_tick(7'd41, 5'sd5, 12'sd300, 1'b1, 1'b1, 1'b1, 1'b0, 32'd97);
		send_tick(7'd100, 5'sd1, 12'sd300, 1'b1, 1'b1, 1'b1, 1'b0, 32'd98);
		send_tick(7'd20, 5'sd4, 12'sd300, 1'b1, 1'b0, 1'b1, 1'b0, 32'd98);
		send_tick(7'd20, 5'sd4, 12'sd300, 1'b1, 1'b1, 1'b0, 1'b0, 32'd99);
		// screen turns bright, then the hot latch between levels 8 and 7
		send_tick(7'd40, 5'sd15, 12'sd300, 1'b1, 1'b1, 1'b1, 1'b0, 32'd100);
		send_tick(7'd39, 5'sd8, 12'sd381, 1'b1, 1'b1, 1'b1, 1'b0, 32'd105);
		send_tick(7'd39, 5'sd7, 12'sd411, 1'b1, 1'b1, 1'b1, 1'b0, 32'd106);
		send_tick(7'd39, 5'sd7, 12'sd415, 1'b1, 1'b1, 1'b1, 1'b0, 32'd107);
		send_tick(7'd36, 5'sd8, 12'sd405, 1'b1, 1'b1, 1'b1, 1'b0, 32'd108);
		send_tick(7'd36, 5'sd3, 12'sd421, 1'b1, 1'b1, 1'b1, 1'b0, 32'd109);
		// bright window expired
		send_tick(7'd31, 5'sd3, 12'sd410, 1'b1, 1'b1, 1'b1, 1'b0, 32'd120);
		send_tick(7'd31, 5'sd4, 12'sd410, 1'b1, 1'b1, 1'b1, 1'b1, 32'd121);
		// bright window across the seconds wrap
		send_tick(7'd29, 5'sd3, 12'sd410, 1'b1, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFA);
		send_tick(7'd35, 5'sd5, 12'sd388, 1'b1, 1'b1, 1'b1, 1'b0, 32'd4);
		send_tick(7'd30, 5'sd6, 12'sd365, 1'b1, 1'b1, 1'b1, 1'b0, 32'd5);
		// floors, ceilings and temperature extremes
		send_tick(7'd30, 5'sd6, 12'sd365, 1'b1, 1'b1, 1'b1, 1'b1, 32'd6);
		send_tick(7'd0, 5'sd9, -12'sd1024, 1'b1, 1'b1, 1'b1, 1'b1, 32'd7);
		send_tick(7'd20, 5'sd10, 12'sd2047, 1'b1, 1'b1, 1'b1, 1'b1, 32'd8);
		send_tick(7'd39, 5'sd7, 12'sd381, 1'b1, 1'b1, 1'b1, 1'b1, 32'd9);
		send_tick(7'd36, 5'sd2, 12'sd391, 1'b1, 1'b1, 1'b1, 1'b1, 32'd10);
		send_tick(7'd36, 5'sd1, 12'sd391, 1'b1, 1'b1, 1'b1, 1'b1, 32'd11);
		clock_s = 32'd1000;
	endtask

	task automatic test_config_sweep();
		wait_idle();
		write_reg(REG_PARSE_ERROR, 4'd1);
		send_tick(7'd20, 5'sd5, 12'sd300, 1'b1, 1'b1, 1'b1, 1'b0, clock_s);
		repeat (40) send_random_item();
		wait_idle();
		write_reg(REG_PARSE_ERROR, 4'd0);
		write_reg(REG_LEVEL_COUNT, 4'd0);
		repeat (40) send_random_item();
		wait_idle();
		write_reg(REG_LEVEL_COUNT, 4'd7);
		repeat (60) send_random_item();
		wait_idle();
		write_reg(REG_LEVEL_COUNT, 4'd15);
	endtask

	task automatic test_random_traffic(input int n);
		for (int i = 0; i < n; i++) begin
			// one long stretch with no idling on either side
			calm = (i >= n / 3) && (i < n / 3 + 250);
			send_random_item();
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = REG_PARSE_ERROR;
		cfg_data = 4'd0;
		in_valid = 1'b0;
		cmd = CMD_TICK;
		table_index = 4'd0;
		table_value = 16'd0;
		soc = 7'd0;
		temp_level = 5'sd0;
		board_temp = 12'sd0;
		pps_active = 1'b0;
		plugin_flag = 1'b0;
		low_fast_enabled = 1'b0;
		screen_black = 1'b0;
		now_seconds = 32'd0;
		calm = 1'b0;
		clock_s = 32'd0;
		ph_screen = SCR_NORMAL;
		bright_t0 = 32'd0;
		prev_lvl = 0;
		latch_hot = 1'b0;
		held_fast = 1'b0;
		cfg_parse_err = 1'b0;
		cfg_top_level = 4'd15;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_table_load();
		test_directed_ticks();
		test_config_sweep();
		test_random_traffic(1200);

		in_valid <= 1'b0;
		while (pending_votes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("covered %0d table loads and %0d ticks over %0d register settings",
			n_loads, n_ticks, n_settings);
		$display("%0d results checked, %0d limits voted (%0d in fast mode), %0d mismatches",
			n_results, n_votes, n_fast_votes, mismatches);
		if (mismatches == 0 && pending_votes.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/lfctp_pkg.sv
rtl/lfctp_ram.sv
rtl/low_fast_charge_thermal_policy_unit.sv
rtl/lfctp_checker.sv
tb/tb_low_fast_charge_thermal_policy_unit.sv
